@@ sv/lfw_pkg.sv @@
// Shared types, constants and the control store for the linear fade weight envelope.
// No dependencies; every other file imports this package.
package lfw_pkg;

    localparam int TimeW    = 24;
    localparam int WeightW  = 16;
    localparam int DtW      = 16;
    localparam int CmdW     = 2;
    localparam int PhaseW   = 2;
    localparam int CfgIdxW  = 1;
    localparam int ProdW    = 2 * TimeW;
    localparam int DivSteps = ProdW;
    localparam int CntW     = $clog2(DivSteps + 1);
    localparam int PcW      = 6;
    localparam int LastStep = 46;

    // commands
    localparam logic [CmdW-1:0] CMD_TICK     = 2'd0;
    localparam logic [CmdW-1:0] CMD_FADE_OUT = 2'd1;
    localparam logic [CmdW-1:0] CMD_SET      = 2'd2;

    // envelope phases
    localparam logic [PhaseW-1:0] PH_FADING_IN  = 2'd0;
    localparam logic [PhaseW-1:0] PH_FADED_IN   = 2'd1;
    localparam logic [PhaseW-1:0] PH_FADING_OUT = 2'd2;
    localparam logic [PhaseW-1:0] PH_FADED_OUT  = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_FADE_IN  = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_FADE_OUT = 1'd1;

    // duration / multiplier operand selects
    localparam logic DSEL_IN     = 1'b0;
    localparam logic DSEL_OUT    = 1'b1;
    localparam logic MSEL_TARGET = 1'b0;
    localparam logic MSEL_FOUT   = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TIMER_ADD,
        OP_TIMER_SUB,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_W_QUOT,
        OP_W_TARGET,
        OP_W_ZERO,
        OP_T_QUOT,
        OP_T_FOUT,
        OP_SET_TARGET,
        OP_PH_IN_CHK,
        OP_PH_OUT_CHK,
        OP_PH_FADEOUT,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ITEM,
        C_NOT_TICK,
        C_NOT_FADE,
        C_NOT_SET,
        C_PH_IN,
        C_NOT_PH_IN,
        C_PH_OUT,
        C_DUR_ZERO,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op            op;
        t_cond          cond;
        logic           dsel;
        logic           msel;
        logic [PcW-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic dsel;
        logic msel;
    } t_ctrl;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic              dur_zero;
        logic              div_more;
    } t_dstat;

    // channel flags seen by the sequencer
    typedef struct packed {
        logic            item;
        logic [CmdW-1:0] cmd;
        logic            out_busy;
    } t_tstat;

    // routine entry points
    localparam logic [PcW-1:0] L_IDLE     = 6'd0;
    localparam logic [PcW-1:0] L_TIN_Z    = 6'd10;
    localparam logic [PcW-1:0] L_TIN_CHK  = 6'd11;
    localparam logic [PcW-1:0] L_TOUT     = 6'd12;
    localparam logic [PcW-1:0] L_TOUT_Z   = 6'd18;
    localparam logic [PcW-1:0] L_TOUT_CHK = 6'd19;
    localparam logic [PcW-1:0] L_FADE     = 6'd20;
    localparam logic [PcW-1:0] L_FO_FULL  = 6'd28;
    localparam logic [PcW-1:0] L_FO_PH    = 6'd29;
    localparam logic [PcW-1:0] L_SET      = 6'd30;
    localparam logic [PcW-1:0] L_SET_TGT  = 6'd34;
    localparam logic [PcW-1:0] L_SET_IN   = 6'd35;
    localparam logic [PcW-1:0] L_SET_OUT  = 6'd40;
    localparam logic [PcW-1:0] L_DONE     = 6'd45;

    function automatic t_uword uw(t_op op, t_cond cond, logic dsel, logic msel,
                                  logic [PcW-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.dsel   = dsel;
        w.msel   = msel;
        w.target = target;
        return w;
    endfunction

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword useq_rom(logic [PcW-1:0] pc);
        t_uword w;
        case (pc)
            // dispatch
            6'd0:  w = uw(OP_NOP,        C_NO_ITEM,  DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd1:  w = uw(OP_NOP,        C_NOT_TICK, DSEL_IN,  MSEL_TARGET, L_FADE);
            6'd2:  w = uw(OP_NOP,        C_PH_OUT,   DSEL_IN,  MSEL_TARGET, L_TOUT);
            6'd3:  w = uw(OP_NOP,        C_NOT_PH_IN, DSEL_IN, MSEL_TARGET, L_DONE);
            // tick, fading in
            6'd4:  w = uw(OP_TIMER_ADD,  C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd5:  w = uw(OP_NOP,        C_DUR_ZERO, DSEL_IN,  MSEL_TARGET, L_TIN_Z);
            6'd6:  w = uw(OP_MUL,        C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd7:  w = uw(OP_DIV_INIT,   C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd8:  w = uw(OP_DIV_STEP,   C_DIV_MORE, DSEL_IN,  MSEL_TARGET, 6'd8);
            6'd9:  w = uw(OP_W_QUOT,     C_ALWAYS,   DSEL_IN,  MSEL_TARGET, L_TIN_CHK);
            6'd10: w = uw(OP_W_TARGET,   C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd11: w = uw(OP_PH_IN_CHK,  C_ALWAYS,   DSEL_IN,  MSEL_TARGET, L_DONE);
            // tick, fading out
            6'd12: w = uw(OP_TIMER_SUB,  C_NONE,     DSEL_OUT, MSEL_TARGET, L_IDLE);
            6'd13: w = uw(OP_NOP,        C_DUR_ZERO, DSEL_OUT, MSEL_TARGET, L_TOUT_Z);
            6'd14: w = uw(OP_MUL,        C_NONE,     DSEL_OUT, MSEL_TARGET, L_IDLE);
            6'd15: w = uw(OP_DIV_INIT,   C_NONE,     DSEL_OUT, MSEL_TARGET, L_IDLE);
            6'd16: w = uw(OP_DIV_STEP,   C_DIV_MORE, DSEL_OUT, MSEL_TARGET, 6'd16);
            6'd17: w = uw(OP_W_QUOT,     C_ALWAYS,   DSEL_OUT, MSEL_TARGET, L_TOUT_CHK);
            6'd18: w = uw(OP_W_ZERO,     C_NONE,     DSEL_OUT, MSEL_TARGET, L_IDLE);
            6'd19: w = uw(OP_PH_OUT_CHK, C_ALWAYS,   DSEL_OUT, MSEL_TARGET, L_DONE);
            // start fade out
            6'd20: w = uw(OP_NOP,        C_NOT_FADE, DSEL_IN,  MSEL_FOUT,   L_SET);
            6'd21: w = uw(OP_NOP,        C_PH_OUT,   DSEL_IN,  MSEL_FOUT,   L_FO_PH);
            6'd22: w = uw(OP_NOP,        C_NOT_PH_IN, DSEL_IN, MSEL_FOUT,   L_FO_FULL);
            6'd23: w = uw(OP_NOP,        C_DUR_ZERO, DSEL_IN,  MSEL_FOUT,   L_FO_FULL);
            6'd24: w = uw(OP_MUL,        C_NONE,     DSEL_IN,  MSEL_FOUT,   L_IDLE);
            6'd25: w = uw(OP_DIV_INIT,   C_NONE,     DSEL_IN,  MSEL_FOUT,   L_IDLE);
            6'd26: w = uw(OP_DIV_STEP,   C_DIV_MORE, DSEL_IN,  MSEL_FOUT,   6'd26);
            6'd27: w = uw(OP_T_QUOT,     C_ALWAYS,   DSEL_IN,  MSEL_FOUT,   L_FO_PH);
            6'd28: w = uw(OP_T_FOUT,     C_NONE,     DSEL_IN,  MSEL_FOUT,   L_IDLE);
            6'd29: w = uw(OP_PH_FADEOUT, C_ALWAYS,   DSEL_IN,  MSEL_FOUT,   L_DONE);
            // set target weight
            6'd30: w = uw(OP_NOP,        C_NOT_SET,  DSEL_IN,  MSEL_TARGET, L_DONE);
            6'd31: w = uw(OP_SET_TARGET, C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd32: w = uw(OP_NOP,        C_PH_IN,    DSEL_IN,  MSEL_TARGET, L_SET_IN);
            6'd33: w = uw(OP_NOP,        C_PH_OUT,   DSEL_IN,  MSEL_TARGET, L_SET_OUT);
            6'd34: w = uw(OP_W_TARGET,   C_ALWAYS,   DSEL_IN,  MSEL_TARGET, L_DONE);
            6'd35: w = uw(OP_NOP,        C_DUR_ZERO, DSEL_IN,  MSEL_TARGET, L_SET_TGT);
            6'd36: w = uw(OP_MUL,        C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd37: w = uw(OP_DIV_INIT,   C_NONE,     DSEL_IN,  MSEL_TARGET, L_IDLE);
            6'd38: w = uw(OP_DIV_STEP,   C_DIV_MORE, DSEL_IN,  MSEL_TARGET, 6'd38);
            6'd39: w = uw(OP_W_QUOT,     C_ALWAYS,   DSEL_IN,  MSEL_TARGET, L_DONE);
            6'd40: w = uw(OP_NOP,        C_DUR_ZERO, DSEL_OUT, MSEL_TARGET, L_SET_TGT);
            6'd41: w = uw(OP_MUL,        C_NONE,     DSEL_OUT, MSEL_TARGET, L_IDLE);
            6'd42: w = uw(OP_DIV_INIT,   C_NONE,     DSEL_OUT, MSEL_TARGET, L_IDLE);
            6'd43: w = uw(OP_DIV_STEP,   C_DIV_MORE, DSEL_OUT, MSEL_TARGET, 6'd43);
            6'd44: w = uw(OP_W_QUOT,     C_ALWAYS,   DSEL_OUT, MSEL_TARGET, L_DONE);
            // hand the result to the output register
            6'd45: w = uw(OP_NOP,        C_OUT_BUSY, DSEL_IN,  MSEL_TARGET, L_DONE);
            6'd46: w = uw(OP_EMIT,       C_ALWAYS,   DSEL_IN,  MSEL_TARGET, L_IDLE);
            default: w = uw(OP_NOP,      C_ALWAYS,   DSEL_IN,  MSEL_TARGET, L_IDLE);
        endcase
        return w;
    endfunction

endpackage

@@ sv/lfw_in_if.sv @@
// Input channel of the fade envelope: valid/ready plus one command item.
// Depends on lfw_pkg for field widths.
interface lfw_in_if;
    import lfw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CmdW-1:0]     command;
    logic [DtW-1:0]      delta_time;
    logic [WeightW-1:0]  new_weight;

    modport source (output valid, output command, output delta_time, output new_weight,
                    input ready);
    modport sink   (input valid, input command, input delta_time, input new_weight,
                    output ready);
endinterface

@@ sv/lfw_out_if.sv @@
// Output channel of the fade envelope: valid/ready plus one result item.
// Depends on lfw_pkg for field widths.
interface lfw_out_if;
    import lfw_pkg::*;

    logic                valid;
    logic                ready;
    logic [WeightW-1:0]  current_weight;
    logic [PhaseW-1:0]   phase;

    modport source (output valid, output current_weight, output phase, input ready);
    modport sink   (input valid, input current_weight, input phase, output ready);
endinterface

@@ sv/lfw_useq.sv @@
// Microcode sequencer: step counter, control store lookup, jump condition select.
// Depends on lfw_pkg (control word layout and program).
module lfw_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lfw_pkg::t_dstat i_dstat,
    input  lfw_pkg::t_tstat i_tstat,
    output lfw_pkg::t_ctrl  o_ctrl,
    output logic            o_idle
);
    import lfw_pkg::*;

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    t_uword         word;
    logic           take;

    assign word = useq_rom(r_pc);

    always_comb begin
        case (word.cond)
            C_NONE:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ITEM:   take = !i_tstat.item;
            C_NOT_TICK:  take = i_tstat.cmd != CMD_TICK;
            C_NOT_FADE:  take = i_tstat.cmd != CMD_FADE_OUT;
            C_NOT_SET:   take = i_tstat.cmd != CMD_SET;
            C_PH_IN:     take = i_dstat.phase == PH_FADING_IN;
            C_NOT_PH_IN: take = i_dstat.phase != PH_FADING_IN;
            C_PH_OUT:    take = i_dstat.phase == PH_FADING_OUT;
            C_DUR_ZERO:  take = i_dstat.dur_zero;
            C_DIV_MORE:  take = i_dstat.div_more;
            C_OUT_BUSY:  take = i_tstat.out_busy;
            default:     take = 1'b1;
        endcase
        n_pc = take ? word.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op   = word.op;
    assign o_ctrl.dsel = word.dsel;
    assign o_ctrl.msel = word.msel;
    assign o_idle      = r_pc == L_IDLE;

`ifndef SYNTH
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PcW'(LastStep))
        else $error("step counter left the program");
`endif

endmodule

@@ sv/lfw_dpath.sv @@
// Envelope datapath: timer, target, weight, phase, 24x24 multiplier and a
// restoring divider that yields one quotient bit per DIV_STEP. Depends on lfw_pkg.
module lfw_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfw_pkg::t_ctrl                i_ctrl,
    input  logic [lfw_pkg::DtW-1:0]       i_dt,
    input  logic [lfw_pkg::WeightW-1:0]   i_w,
    input  logic [lfw_pkg::TimeW-1:0]     i_fin,
    input  logic [lfw_pkg::TimeW-1:0]     i_fout,
    output logic [lfw_pkg::WeightW-1:0]   o_weight,
    output logic [lfw_pkg::PhaseW-1:0]    o_phase,
    output lfw_pkg::t_dstat               o_dstat
);
    import lfw_pkg::*;

    logic [TimeW-1:0]   r_timer,  n_timer;
    logic [WeightW-1:0] r_target, n_target;
    logic [WeightW-1:0] r_weight, n_weight;
    logic [PhaseW-1:0]  r_phase,  n_phase;
    logic [ProdW-1:0]   r_prod,   n_prod;
    logic [ProdW-1:0]   r_quo,    n_quo;
    logic [TimeW-1:0]   r_rem,    n_rem;
    logic [TimeW-1:0]   r_dvs,    n_dvs;
    logic [CntW-1:0]    r_cnt,    n_cnt;

    logic [TimeW-1:0]   dur;
    logic [TimeW-1:0]   mul_b;
    logic [TimeW:0]     sum;
    logic [TimeW:0]     shifted;
    logic [TimeW:0]     diff;
    logic               fits;
    logic [WeightW-1:0] q_w;
    logic [TimeW-1:0]   q_t;

    assign dur   = (i_ctrl.dsel == DSEL_OUT) ? i_fout : i_fin;
    assign mul_b = (i_ctrl.msel == MSEL_FOUT) ? i_fout : TimeW'(r_target);
    assign sum   = {1'b0, r_timer} + (TimeW + 1)'(i_dt);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[ProdW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    // saturate the quotient to the destination width
    assign q_w = (|r_quo[ProdW-1:WeightW]) ? {WeightW{1'b1}} : r_quo[WeightW-1:0];
    assign q_t = (|r_quo[ProdW-1:TimeW])   ? {TimeW{1'b1}}   : r_quo[TimeW-1:0];

    always_comb begin
        n_timer  = r_timer;
        n_target = r_target;
        n_weight = r_weight;
        n_phase  = r_phase;
        n_prod   = r_prod;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_cnt    = r_cnt;
        case (i_ctrl.op)
            OP_TIMER_ADD: begin
                n_timer = (sum < {1'b0, i_fin}) ? sum[TimeW-1:0] : i_fin;
            end
            OP_TIMER_SUB: begin
                n_timer = (r_timer > TimeW'(i_dt)) ? r_timer - TimeW'(i_dt) : '0;
            end
            OP_MUL: begin
                n_prod = r_timer * mul_b;
            end
            OP_DIV_INIT: begin
                n_quo = r_prod;
                n_rem = '0;
                n_dvs = dur;
                n_cnt = CntW'(DivSteps);
            end
            OP_DIV_STEP: begin
                n_rem = fits ? diff[TimeW-1:0] : shifted[TimeW-1:0];
                n_quo = {r_quo[ProdW-2:0], fits};
                n_cnt = r_cnt - 1'b1;
            end
            OP_W_QUOT:     n_weight = q_w;
            OP_W_TARGET:   n_weight = r_target;
            OP_W_ZERO:     n_weight = '0;
            OP_T_QUOT:     n_timer  = q_t;
            OP_T_FOUT:     n_timer  = i_fout;
            OP_SET_TARGET: n_target = i_w;
            OP_PH_IN_CHK: begin
                if (r_weight == r_target) begin
                    n_phase = PH_FADED_IN;
                end
            end
            OP_PH_OUT_CHK: begin
                if (r_weight == '0) begin
                    n_phase = PH_FADED_OUT;
                end
            end
            OP_PH_FADEOUT: begin
                n_phase  = (i_fout != '0) ? PH_FADING_OUT : PH_FADED_OUT;
                n_weight = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer  <= '0;
            r_target <= '0;
            r_weight <= '0;
            r_phase  <= PH_FADING_IN;
            r_cnt    <= '0;
        end else begin
            r_timer  <= n_timer;
            r_target <= n_target;
            r_weight <= n_weight;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_weight         = r_weight;
    assign o_phase          = r_phase;
    assign o_dstat.phase    = r_phase;
    assign o_dstat.dur_zero = dur == '0;
    assign o_dstat.div_more = r_cnt != CntW'(1);

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.op == OP_DIV_STEP |-> r_dvs != '0)
        else $error("division started with a zero duration");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.op == OP_DIV_STEP |-> r_rem < r_dvs)
        else $error("divider remainder not below divisor");
`endif

endmodule

@@ sv/linear_fade_weight_envelope.sv @@
// Linear fade weight envelope. Each accepted item (tick, start fade-out, set
// target) yields exactly one result item with the Q2.14 weight and phase.
// Items are taken one at a time: the input is ready only while the microcode
// sequencer is idle, and it may take the next item while the last result still
// waits in the output register. A ramp update or a fade-out rescale runs the
// 48-step restoring divider that produces one quotient bit per cycle; commands
// without a ramp, or with a zero duration, skip the divider. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Depends on lfw_pkg, lfw_in_if, lfw_out_if, lfw_useq and lfw_dpath.
module linear_fade_weight_envelope (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lfw_in_if.sink                        i_item,
    lfw_out_if.source                     o_result,
    input  logic                          i_cfg_we,
    input  logic [lfw_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [lfw_pkg::TimeW-1:0]     i_cfg_data
);
    import lfw_pkg::*;

    logic [TimeW-1:0]   r_fin;
    logic [TimeW-1:0]   r_fout;
    logic [CmdW-1:0]    r_cmd;
    logic [DtW-1:0]     r_dt;
    logic [WeightW-1:0] r_w;
    logic               r_out_valid;
    logic [WeightW-1:0] r_out_weight;
    logic [PhaseW-1:0]  r_out_phase;

    t_ctrl              ctrl;
    t_dstat             dstat;
    t_tstat             tstat;
    logic               idle;
    logic               in_fire;
    logic [WeightW-1:0] weight;
    logic [PhaseW-1:0]  phase;

    assign i_item.ready = idle;
    assign in_fire      = i_item.valid && idle;

    assign tstat.item     = in_fire;
    assign tstat.cmd      = r_cmd;
    assign tstat.out_busy = r_out_valid && !o_result.ready;

    lfw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dstat (dstat),
        .i_tstat (tstat),
        .o_ctrl  (ctrl),
        .o_idle  (idle)
    );

    lfw_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_dt     (r_dt),
        .i_w      (r_w),
        .i_fin    (r_fin),
        .i_fout   (r_fout),
        .o_weight (weight),
        .o_phase  (phase),
        .o_dstat  (dstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin  <= '0;
            r_fout <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FADE_IN:  r_fin  <= i_cfg_data;
                REG_FADE_OUT: r_fout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_item.command;
            r_dt  <= i_item.delta_time;
            r_w   <= i_item.new_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_EMIT) begin
            r_out_weight <= weight;
            r_out_phase  <= phase;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.current_weight = r_out_weight;
    assign o_result.phase          = r_out_phase;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.op == OP_EMIT |-> !(r_out_valid && !o_result.ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

@@ dv/lfw_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the linear fade weight envelope. It mirrors the two duration
// registers, predicts the weight and phase of every accepted item and checks each result.
// Depends on lfw_pkg, lfw_in_if and lfw_out_if.
module lfw_checker
    import lfw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    lfw_in_if                  i_item,
    lfw_out_if                 i_result,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [TimeW-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [WeightW-1:0] weight;
        logic [PhaseW-1:0]  phase;
    } t_envelope_out;

    t_envelope_out      expected_q[$];
    logic [TimeW-1:0]   fade_in_len;
    logic [TimeW-1:0]   fade_out_len;
    logic [TimeW-1:0]   env_timer;
    logic [WeightW-1:0] env_target;
    logic [WeightW-1:0] env_weight;
    logic [PhaseW-1:0]  env_phase;
    int                 fail_total = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    // target * timer / len, truncated, clipped to the weight width
    function automatic logic [WeightW-1:0] ramp_point(input logic [TimeW-1:0] tmr,
                                                      input logic [WeightW-1:0] tgt,
                                                      input logic [TimeW-1:0] len);
        logic [ProdW-1:0] quo;
        quo = (ProdW'(tmr) * ProdW'(tgt)) / ProdW'(len);
        return (quo[ProdW-1:WeightW] != '0) ? '1 : quo[WeightW-1:0];
    endfunction

    task automatic step_envelope(input logic [CmdW-1:0] cmd, input logic [DtW-1:0] dt,
                                 input logic [WeightW-1:0] w);
        logic [TimeW:0]   sum;
        logic [ProdW-1:0] quo;
        t_envelope_out    res;
        case (cmd)
            CMD_TICK: begin
                if (env_phase == PH_FADING_IN) begin
                    sum = env_timer + dt;
                    env_timer = (sum < {1'b0, fade_in_len}) ? sum[TimeW-1:0] : fade_in_len;
                    env_weight = (fade_in_len != '0)
                               ? ramp_point(env_timer, env_target, fade_in_len) : env_target;
                    if (env_weight == env_target) env_phase = PH_FADED_IN;
                end else if (env_phase == PH_FADING_OUT) begin
                    env_timer = (env_timer > dt) ? env_timer - dt : '0;
                    env_weight = (fade_out_len != '0)
                               ? ramp_point(env_timer, env_target, fade_out_len) : '0;
                    if (env_weight == '0) env_phase = PH_FADED_OUT;
                end
            end
            CMD_FADE_OUT: begin
                if (env_phase == PH_FADED_IN || env_phase == PH_FADED_OUT) begin
                    env_timer = fade_out_len;
                end else if (env_phase == PH_FADING_IN) begin
                    if (fade_in_len == '0) begin
                        env_timer = fade_out_len;
                    end else begin
                        // remaining fade-in time rescaled to the fade-out length
                        quo = (ProdW'(env_timer) * ProdW'(fade_out_len)) / ProdW'(fade_in_len);
                        env_timer = (quo[ProdW-1:TimeW] != '0) ? '1 : quo[TimeW-1:0];
                    end
                end
                env_phase = (fade_out_len != '0) ? PH_FADING_OUT : PH_FADED_OUT;
                env_weight = '0;
            end
            CMD_SET: begin
                env_target = w;
                if (env_phase == PH_FADING_IN) begin
                    env_weight = (fade_in_len != '0)
                               ? ramp_point(env_timer, env_target, fade_in_len) : env_target;
                end else if (env_phase == PH_FADING_OUT) begin
                    env_weight = (fade_out_len != '0)
                               ? ramp_point(env_timer, env_target, fade_out_len) : env_target;
                end else begin
                    env_weight = env_target;
                end
            end
            default: ;
        endcase
        res.weight = env_weight;
        res.phase  = env_phase;
        expected_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_envelope_out want;
        if (!i_rst_n) begin
            fade_in_len  = '0;
            fade_out_len = '0;
            env_timer    = '0;
            env_target   = '0;
            env_weight   = '0;
            env_phase    = PH_FADING_IN;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FADE_IN) fade_in_len = i_cfg_data;
                else if (i_cfg_idx == REG_FADE_OUT) fade_out_len = i_cfg_data;
            end
            // an older result may leave in the same cycle a new item arrives
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result item with nothing pending: weight %0d phase %0d",
                                              i_result.current_weight, i_result.phase));
                end else begin
                    want = expected_q.pop_front();
                    if (i_result.current_weight !== want.weight)
                        report_mismatch($sformatf("weight %0d, expected %0d",
                                                  i_result.current_weight, want.weight));
                    if (i_result.phase !== want.phase)
                        report_mismatch($sformatf("phase %0d, expected %0d",
                                                  i_result.phase, want.phase));
                end
            end
            if (i_item.valid && i_item.ready)
                step_envelope(i_item.command, i_item.delta_time, i_item.new_weight);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the linear fade weight envelope: clock, reset, command items,
// duration writes and result back-pressure; lfw_checker does all the checking.
// Depends on lfw_pkg, lfw_in_if, lfw_out_if, lfw_checker and linear_fade_weight_envelope.
module tb_top;
    import lfw_pkg::*;

    localparam logic [CmdW-1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [TimeW-1:0] DurMax       = '1;
    localparam int               RandomItems  = 1150;
    localparam int               FadeInItems  = 150;
    localparam int               SettleCycles = 80;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [TimeW-1:0]   cfg_data;
    int                 fail_count;
    int                 pending;
    logic               sender_quiet;
    logic               receiver_quiet;
    logic [TimeW-1:0]   cur_fade_out;
    int                 counted_items;

    lfw_in_if  item_ch ();
    lfw_out_if result_ch ();

    linear_fade_weight_envelope u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lfw_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall before each result item
    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = receiver_quiet ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    task automatic send_item(input logic [CmdW-1:0] cmd, input logic [DtW-1:0] dt,
                             input logic [WeightW-1:0] w);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= cmd;
        item_ch.delta_time <= dt;
        item_ch.new_weight <= w;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // hold off until every result is back, then let the sequencer settle
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_durations(input logic [TimeW-1:0] fade_in,
                                   input logic [TimeW-1:0] fade_out);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_FADE_IN;
        cfg_data <= fade_in;
        @(posedge clk);
        cfg_idx  <= REG_FADE_OUT;
        cfg_data <= fade_out;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_fade_out = fade_out;
    endtask

    function automatic logic [TimeW-1:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return DurMax;
            2: return TimeW'(1);
            3, 4, 5: return TimeW'($urandom_range(1, 1000));
            6, 7: return TimeW'($urandom_range(1, 1 << 20));
            default: return TimeW'($urandom);
        endcase
    endfunction

    function automatic logic [WeightW-1:0] pick_weight();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return WeightW'($urandom);
    endfunction

    // mostly fade-out ramps: ticks sized to the fade-out length so ramps complete
    task automatic random_item();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 99);
        span = (cur_fade_out == '0) ? 65535 : cur_fade_out / 3 + 1;
        if (span > 65535) span = 65535;
        if (r < 45) begin
            send_item(CMD_TICK, DtW'($urandom_range(0, span)), WeightW'($urandom));
        end else if (r < 55) begin
            send_item(CMD_TICK, DtW'($urandom), WeightW'($urandom));
        end else if (r < 75) begin
            send_item(CMD_SET, DtW'($urandom), pick_weight());
        end else if (r < 88) begin
            send_item(CMD_FADE_OUT, DtW'($urandom), WeightW'($urandom));
        end else begin
            send_item(CMD_UNUSED, DtW'($urandom), WeightW'($urandom));
        end
        counted_items++;
    endtask

    initial begin
        int          exit_path;
        int unsigned r;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= REG_FADE_IN;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.command    <= CMD_TICK;
        item_ch.delta_time <= '0;
        item_ch.new_weight <= '0;
        sender_quiet       <= 1'b0;
        receiver_quiet     <= 1'b0;
        counted_items = 0;
        cur_fade_out  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fading in is only reachable once after reset, so it comes first
        write_durations('0, '0);
        send_item(CMD_SET, '0, '1);
        send_item(CMD_SET, '0, '0);
        send_item(CMD_UNUSED, '1, '1);
        send_item(CMD_SET, '0, 16'd16384);
        wait_idle();
        write_durations(DurMax, DurMax);
        send_item(CMD_SET, '0, '1);
        send_item(CMD_TICK, '1, '0);
        send_item(CMD_TICK, '0, '1);
        send_item(CMD_SET, '1, 16'd1);
        send_item(CMD_SET, '0, '1);

        // long fade-in: nonzero targets keep the ramp from finishing early
        repeat (FadeInItems) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_item(CMD_TICK, DtW'($urandom), WeightW'($urandom));
            else if (r < 90)
                send_item(CMD_SET, DtW'($urandom), WeightW'($urandom_range(1, 65535)));
            else
                send_item(CMD_UNUSED, DtW'($urandom), WeightW'($urandom));
            if (r % 25 == 0) begin
                sender_quiet   <= ($urandom_range(0, 2) == 0);
                receiver_quiet <= ($urandom_range(0, 2) == 0);
            end
        end
        counted_items += FadeInItems;

        // only one way out of fading in per run
        exit_path = $urandom_range(0, 3);
        wait_idle();
        case (exit_path)
            0: begin
                // zero fade-in length: timer takes the whole fade-out length
                write_durations('0, DurMax);
                send_item(CMD_FADE_OUT, '0, '0);
            end
            1: begin
                write_durations(DurMax, TimeW'($urandom_range(1, 16777215)));
                send_item(CMD_FADE_OUT, '1, '1);
            end
            2: begin
                // fade-in shrunk under the timer: weight and rescaled timer clip
                write_durations(TimeW'($urandom_range(1, 255)), DurMax);
                send_item(CMD_SET, DtW'($urandom), WeightW'($urandom_range(256, 65535)));
                send_item(CMD_FADE_OUT, '0, '0);
            end
            default: begin
                // timer clamps at the fade-in length and the ramp lands on target
                write_durations(TimeW'($urandom_range(1, 1000)), DurMax);
                send_item(CMD_TICK, DtW'($urandom), '0);
                send_item(CMD_SET, '0, WeightW'($urandom));
                send_item(CMD_TICK, '1, '0);
                send_item(CMD_FADE_OUT, '0, '0);
            end
        endcase

        wait_idle();
        write_durations(DurMax, DurMax);
        send_item(CMD_SET, '1, '1);
        send_item(CMD_FADE_OUT, '0, '0);
        send_item(CMD_TICK, '1, '0);
        send_item(CMD_SET, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_SET, '0, '1);
        send_item(CMD_FADE_OUT, '0, '0);
        send_item(CMD_TICK, '0, '0);
        wait_idle();
        // fade-out shrunk under a running timer
        write_durations(DurMax, TimeW'(1));
        send_item(CMD_SET, '0, '1);
        send_item(CMD_TICK, '1, '0);
        wait_idle();
        write_durations('0, '0);
        send_item(CMD_SET, '0, 16'd100);
        send_item(CMD_TICK, 16'd1, '0);
        send_item(CMD_FADE_OUT, '0, '0);

        // random phases; envelope state carries across duration changes
        while (counted_items < RandomItems) begin
            wait_idle();
            write_durations(pick_duration(), pick_duration());
            sender_quiet   <= ($urandom_range(0, 3) == 0);
            receiver_quiet <= ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 60)) random_item();
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
